FILE: design/ffe_pkg.sv
// Package for the framebuffer fill engine: command codes, sizes and state encoding.
// No dependencies; used by framebuffer_fill_engine_unit and its testbench.
`timescale 1ns / 1ps
package ffe_pkg;
    localparam int MaxWidth    = 256;
    localparam int MaxHeight   = 256;
    localparam int XW          = $clog2(MaxWidth);
    localparam int YW          = $clog2(MaxHeight);
    localparam int AW          = XW + YW;
    localparam int Depth       = MaxWidth * MaxHeight;
    localparam logic [31:0] KeyMask = 32'h00FF_FFFF;
    localparam logic [16:0] CountMax = 17'h1_FFFF;

    localparam logic [2:0] REQ_PIXEL  = 3'd0;
    localparam logic [2:0] REQ_RECT   = 3'd1;
    localparam logic [2:0] REQ_CIRCLE = 3'd2;
    localparam logic [2:0] REQ_CLEAR  = 3'd3;
    localparam logic [2:0] REQ_KEY    = 3'd4;
    localparam logic [2:0] REQ_READ   = 3'd5;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ_WAIT,
        ST_ROW_SETUP,
        ST_SQRT,
        ST_SPAN,
        ST_KEY_SCAN,
        ST_KEY_DRAIN,
        ST_DONE
    } state_t;
endpackage

FILE: design/ffe_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ffe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/framebuffer_fill_engine_unit.sv
// Framebuffer fill engine: 2D pixel, rectangle, circle, clear, color key and read commands.
// Pixel writes when accepted and read waits on the registered store; rectangle and clear fill
// pixel by pixel, circle takes a square root per drawn row, color key tests every pixel.
// One request at a time; a result waits in the output register while the next is taken.
// After reset a clearing pass zeroes the frame store before requests start.
// Depends on ffe_pkg and ffe_ram.
`timescale 1ns / 1ps
module framebuffer_fill_engine_unit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [8:0]            cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            req_type,
    input  logic signed [15:0]    pos_x,
    input  logic signed [15:0]    pos_y,
    input  logic [14:0]           rect_width,
    input  logic [14:0]           rect_height,
    input  logic [13:0]           radius,
    input  logic [31:0]           color,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [31:0]           read_color,
    output logic                  in_range,
    output logic [16:0]           pixels_written
);
    import ffe_pkg::*;

    state_t state_reg, state_next;
    logic [8:0] fw_reg, fh_reg;
    logic [8:0] w_eff, h_eff;

    // Command registers.
    logic [2:0]         req_reg;
    logic signed [17:0] px_reg, py_reg;
    logic [31:0]        col_reg;
    logic [16:0]        cnt_reg, cnt_next;
    logic [8:0]         x_reg, x_next, xr_reg, xr_next, xl_reg, xl_next;
    logic [8:0]         y_reg, y_next, yend_reg, yend_next;
    logic               inr_reg, inr_next;
    logic [AW-1:0]      addr_reg, addr_next;
    // Square root iteration.
    logic [27:0]        sq_n_reg, sq_n_next;
    logic [27:0]        sq_res_reg, sq_res_next;
    logic [27:0]        sq_bit_reg, sq_bit_next;
    logic [27:0]        r2_reg;
    logic [4:0]         sq_cnt_reg, sq_cnt_next;
    // Color key pipeline: address of the pixel whose read data arrives this cycle.
    logic               kv_reg, kv_next;
    logic [AW-1:0]      ka_reg, ka_next;
    logic               ovalid_reg, ovalid_next;
    logic [31:0]        ocol_reg, ocol_next;
    logic               oinr_reg, oinr_next;
    logic [16:0]        ocnt_reg, ocnt_next;

    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [31:0]        wdata, rdata;

    ffe_ram #(.WIDTH(32), .DEPTH(Depth)) u_store (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    assign w_eff = (fw_reg == 9'd0) ? 9'd1 : ((fw_reg > 9'(MaxWidth)) ? 9'(MaxWidth) : fw_reg);
    assign h_eff = (fh_reg == 9'd0) ? 9'd1
                 : ((fh_reg > 9'(MaxHeight)) ? 9'(MaxHeight) : fh_reg);

    logic accept, done_free;
    assign done_free = !ovalid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;

    // Span arithmetic on 18-bit signed values.
    logic signed [17:0] sx, sy, sw1, sh1, rl, rr, rt, rb, dy, sp, cy0, cy1;
    logic [17:0] ady;
    logic [27:0] dy2;
    logic signed [29:0] s2;
    logic [16:0] cnt_inc;

    function automatic logic signed [17:0] clampv(input logic signed [17:0] v,
                                                  input logic signed [17:0] lo,
                                                  input logic signed [17:0] hi);
        logic signed [17:0] r;
        begin
            r = (v < lo) ? lo : ((v > hi) ? hi : v);
            return r;
        end
    endfunction

    always_comb
    begin
        sx  = 18'(pos_x);
        sy  = 18'(pos_y);
        sw1 = 18'(w_eff);
        sh1 = 18'(h_eff);
        rl  = clampv(sx, 18'sd0, sw1);
        rr  = clampv(sx + 18'(rect_width), 18'sd0, sw1);
        rt  = clampv(sy, 18'sd0, sh1);
        rb  = clampv(sy + 18'(rect_height), 18'sd0, sh1);
        cy0 = clampv(sy - 18'(radius), 18'sd0, sh1);
        cy1 = clampv(sy + 18'(radius), -18'sd1, sh1 - 18'sd1);
        dy  = 18'(y_reg) - py_reg;
        // Rows stay within the radius of the center, so the distance fits in 14 bits.
        ady = dy[17] ? -dy : dy;
        dy2 = 28'(ady[13:0] * ady[13:0]);
        s2  = 30'(r2_reg) - 30'(dy2);
        sp  = 18'(sq_res_reg[13:0]);
        cnt_inc = (cnt_reg == CountMax) ? cnt_reg : cnt_reg + 17'd1;
    end

    logic signed [17:0] sl, sr;
    assign sl = (px_reg - sp < 18'sd0) ? 18'sd0 : px_reg - sp;
    assign sr = (px_reg + sp > sw1 - 18'sd1) ? sw1 - 18'sd1 : px_reg + sp;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        x_next      = x_reg;
        xl_next     = xl_reg;
        xr_next     = xr_reg;
        y_next      = y_reg;
        yend_next   = yend_reg;
        inr_next    = inr_reg;
        addr_next   = addr_reg;
        sq_n_next   = sq_n_reg;
        sq_res_next = sq_res_reg;
        sq_bit_next = sq_bit_reg;
        sq_cnt_next = sq_cnt_reg;
        kv_next     = 1'b0;
        ka_next     = ka_reg;
        ovalid_next = ovalid_reg && out_stall;
        ocol_next   = ocol_reg;
        oinr_next   = oinr_reg;
        ocnt_next   = ocnt_reg;
        we          = 1'b0;
        waddr       = {y_reg[YW-1:0], x_reg[XW-1:0]};
        wdata       = col_reg;
        raddr       = addr_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                we    = 1'b1;
                waddr = addr_reg;
                wdata = '0;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == AW'(Depth - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    inr_next = 1'b0;
                    unique case (req_type)
                        REQ_PIXEL, REQ_READ:
                        begin
                            inr_next  = (sx >= 0) && (sy >= 0) && (sx < sw1) && (sy < sh1);
                            addr_next = {sy[YW-1:0], sx[XW-1:0]};
                            if (req_type == REQ_PIXEL)
                            begin
                                we    = inr_next;
                                waddr = {sy[YW-1:0], sx[XW-1:0]};
                                wdata = color;
                                cnt_next = {16'd0, inr_next};
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                raddr = {sy[YW-1:0], sx[XW-1:0]};
                                state_next = ST_READ_WAIT;
                            end
                        end
                        REQ_RECT:
                        begin
                            x_next = rl[8:0]; xl_next = rl[8:0];
                            xr_next = rr[8:0] - 9'd1;
                            y_next = rt[8:0]; yend_next = rb[8:0];
                            if (rect_width != 0 && rect_height != 0 && rl < rr && rt < rb)
                                state_next = ST_SPAN;
                            else
                                state_next = ST_DONE;
                        end
                        REQ_CIRCLE:
                        begin
                            y_next = cy0[8:0];
                            if (radius != 0 && cy0 <= cy1)
                            begin
                                yend_next = cy1[8:0];
                                state_next = ST_ROW_SETUP;
                            end
                            else
                                state_next = ST_DONE;
                        end
                        REQ_CLEAR:
                        begin
                            x_next = '0; xl_next = '0; xr_next = w_eff - 9'd1;
                            y_next = '0; yend_next = h_eff;
                            state_next = ST_SPAN;
                        end
                        REQ_KEY:
                        begin
                            x_next = '0; y_next = '0;
                            state_next = ST_KEY_SCAN;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_READ_WAIT:
            begin
                state_next = ST_DONE;
            end
            ST_ROW_SETUP:
            begin
                if (s2 < 0)
                begin
                    if (y_reg == yend_reg) state_next = ST_DONE;
                    else y_next = y_reg + 9'd1;
                end
                else
                begin
                    sq_n_next   = s2[27:0];
                    sq_res_next = '0;
                    sq_bit_next = 28'd1 << 26;
                    sq_cnt_next = 5'd14;
                    state_next  = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                // One result bit per cycle of the restoring square root.
                if (sq_n_reg >= sq_res_reg + sq_bit_reg)
                begin
                    sq_n_next   = sq_n_reg - (sq_res_reg + sq_bit_reg);
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_next = sq_res_reg >> 1;
                sq_bit_next = sq_bit_reg >> 2;
                sq_cnt_next = sq_cnt_reg - 5'd1;
                if (sq_cnt_reg == 5'd1)
                begin
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN:
            begin
                // On the first cycle of a circle row the span bounds are set from the root.
                if (req_reg == REQ_CIRCLE && sq_cnt_reg == 5'd0)
                begin
                    sq_cnt_next = 5'd31;
                    if (sl > sr || px_reg + sp < 0 || px_reg - sp > sw1 - 18'sd1)
                    begin
                        if (y_reg == yend_reg) state_next = ST_DONE;
                        else
                        begin
                            y_next = y_reg + 9'd1;
                            state_next = ST_ROW_SETUP;
                        end
                    end
                    else
                    begin
                        x_next = sl[8:0]; xr_next = sr[8:0];
                    end
                end
                else
                begin
                    we = 1'b1;
                    cnt_next = cnt_inc;
                    if (x_reg == xr_reg)
                    begin
                        x_next = xl_reg;
                        y_next = y_reg + 9'd1;
                        if (req_reg == REQ_CIRCLE)
                        begin
                            sq_cnt_next = '0;
                            state_next = (y_reg == yend_reg) ? ST_DONE : ST_ROW_SETUP;
                        end
                        else if (y_reg + 9'd1 == yend_reg)
                            state_next = ST_DONE;
                    end
                    else
                        x_next = x_reg + 9'd1;
                end
            end
            ST_KEY_SCAN:
            begin
                // Read one pixel a cycle; the previous read's data is tested and cleared on a key match.
                raddr = {y_reg[YW-1:0], x_reg[XW-1:0]};
                kv_next = 1'b1;
                ka_next = {y_reg[YW-1:0], x_reg[XW-1:0]};
                if (x_reg == w_eff - 9'd1)
                begin
                    x_next = '0;
                    y_next = y_reg + 9'd1;
                    if (y_reg == h_eff - 9'd1) state_next = ST_KEY_DRAIN;
                end
                else
                    x_next = x_reg + 9'd1;
            end
            ST_KEY_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (done_free)
                begin
                    ovalid_next = 1'b1;
                    ocol_next   = (req_reg == REQ_READ && inr_reg) ? rdata : '0;
                    oinr_next   = inr_reg && (req_reg == REQ_PIXEL || req_reg == REQ_READ);
                    ocnt_next   = cnt_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (kv_reg && ((rdata & KeyMask) == (col_reg & KeyMask)))
        begin
            we = 1'b1;
            waddr = ka_reg;
            wdata = '0;
            cnt_next = cnt_inc;
        end
        // The read address must hold while a read result sits in ST_DONE.
        if (state_reg == ST_DONE || state_reg == ST_READ_WAIT)
            raddr = addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            fw_reg     <= 9'd256;
            fh_reg     <= 9'd256;
            addr_reg   <= '0;
            ovalid_reg <= 1'b0;
            kv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            ovalid_reg <= ovalid_next;
            kv_reg     <= kv_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_WIDTH) fw_reg <= cfg_data;
                else fh_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            px_reg  <= 18'(pos_x);
            py_reg  <= 18'(pos_y);
            col_reg <= color;
            r2_reg  <= 28'(radius * radius);
        end
        cnt_reg    <= cnt_next;
        x_reg      <= x_next;
        xl_reg     <= xl_next;
        xr_reg     <= xr_next;
        y_reg      <= y_next;
        yend_reg   <= yend_next;
        inr_reg    <= inr_next;
        sq_n_reg   <= sq_n_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
        sq_cnt_reg <= sq_cnt_next;
        ka_reg     <= ka_next;
        ocol_reg   <= ocol_next;
        oinr_reg   <= oinr_next;
        ocnt_reg   <= ocnt_next;
    end

    assign out_valid      = ovalid_reg;
    assign read_color     = ocol_reg;
    assign in_range       = oinr_reg;
    assign pixels_written = ocnt_reg;
endmodule

FILE: dv/framebuffer_fill_engine_unit_test.sv
// Testbench for framebuffer_fill_engine_unit: directed and random drawing commands, checked
// against a scoreboard that keeps its own copy of the frame store.
// Depends on ffe_pkg and the design sources.
`timescale 1ns / 1ps
module framebuffer_fill_engine_unit_test;
    import ffe_pkg::*;

    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;
    localparam longint CycleLimit = 4_000_000;

    typedef struct {
        logic [2:0]         op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        rw;
        logic [14:0]        rh;
        logic [13:0]        rad;
        logic [31:0]        col;
    } draw_cmd_t;

    typedef struct {
        logic [31:0] rd;
        logic        inr;
        logic [16:0] cnt;
    } draw_result_t;

    class frame_scoreboard;
        logic [31:0]  pixels [Depth];
        int           fw = 256;
        int           fh = 256;
        draw_result_t pending [$];
        int           errors = 0;
        int           checked = 0;

        function new();
            foreach (pixels[i]) pixels[i] = '0;
        endfunction

        function void set_size(logic idx, logic [8:0] val);
            int eff;
            eff = (val == 0) ? 1 : ((val > 256) ? 256 : int'(val));
            if (idx == CFG_WIDTH) fw = eff;
            else fh = eff;
        endfunction

        function longint floor_root(longint n);
            longint s;
            s = longint'($sqrt(real'(n)));
            while (s * s > n) s--;
            while ((s + 1) * (s + 1) <= n) s++;
            return s;
        endfunction

        function longint paint_row(longint row, longint lo, longint hi, logic [31:0] c);
            for (longint xx = lo; xx <= hi; xx++) pixels[row * MaxWidth + xx] = c;
            return hi - lo + 1;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void note(draw_cmd_t c);
            longint px, py, cnt, lo, hi, top, bot, span, s2;
            draw_result_t r;
            px = longint'(c.x);
            py = longint'(c.y);
            cnt = 0;
            r.rd = '0;
            r.inr = 1'b0;
            case (c.op)
                REQ_PIXEL, REQ_READ:
                begin
                    if (px >= 0 && py >= 0 && px < fw && py < fh)
                    begin
                        r.inr = 1'b1;
                        if (c.op == REQ_PIXEL)
                        begin
                            pixels[py * MaxWidth + px] = c.col;
                            cnt = 1;
                        end
                        else r.rd = pixels[py * MaxWidth + px];
                    end
                end
                REQ_RECT:
                begin
                    if (c.rw > 0 && c.rh > 0)
                    begin
                        lo = clip(px, 0, fw);
                        top = clip(py, 0, fh);
                        hi = clip(px + c.rw, 0, fw);
                        bot = clip(py + c.rh, 0, fh);
                        if (lo < hi)
                            for (longint yy = top; yy < bot; yy++)
                                cnt += paint_row(yy, lo, hi - 1, c.col);
                    end
                end
                REQ_CIRCLE:
                begin
                    if (c.rad > 0)
                    begin
                        top = clip(py - c.rad, 0, fh);
                        bot = clip(py + c.rad, -1, fh - 1);
                        for (longint yy = top; yy <= bot; yy++)
                        begin
                            s2 = longint'(c.rad) * c.rad - (yy - py) * (yy - py);
                            if (s2 >= 0)
                            begin
                                span = floor_root(s2);
                                lo = (px - span < 0) ? 0 : px - span;
                                hi = (px + span > fw - 1) ? fw - 1 : px + span;
                                if (lo <= hi) cnt += paint_row(yy, lo, hi, c.col);
                            end
                        end
                    end
                end
                REQ_CLEAR:
                begin
                    for (longint yy = 0; yy < fh; yy++) cnt += paint_row(yy, 0, fw - 1, c.col);
                end
                REQ_KEY:
                begin
                    for (longint yy = 0; yy < fh; yy++)
                        for (longint xx = 0; xx < fw; xx++)
                            if ((pixels[yy * MaxWidth + xx] & KeyMask) == (c.col & KeyMask))
                            begin
                                pixels[yy * MaxWidth + xx] = '0;
                                cnt++;
                            end
                end
                default: ;
            endcase
            r.cnt = (cnt > CountMax) ? CountMax : cnt[16:0];
            pending.push_back(r);
        endfunction

        function void check(draw_result_t got);
            draw_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result: read_color %h in_range %b pixels_written %0d",
                       got.rd, got.inr, got.cnt);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.rd !== e.rd)
            begin
                $error("read_color expected %h actual %h", e.rd, got.rd);
                errors++;
            end
            if (got.inr !== e.inr)
            begin
                $error("in_range expected %b actual %b", e.inr, got.inr);
                errors++;
            end
            if (got.cnt !== e.cnt)
            begin
                $error("pixels_written expected %0d actual %0d", e.cnt, got.cnt);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [8:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] req_type = '0;
    logic signed [15:0] pos_x = '0;
    logic signed [15:0] pos_y = '0;
    logic [14:0] rect_width = '0;
    logic [14:0] rect_height = '0;
    logic [13:0] radius = '0;
    logic [31:0] color = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [31:0] read_color;
    logic in_range;
    logic [16:0] pixels_written;

    frame_scoreboard sb = new();
    int  tx_pct = 33;
    int  rx_pct = 47;
    bit  hold_req = 0;
    int  hold_cnt = 0;
    longint cycles = 0;
    int  sent = 0;
    logic [31:0] last_color = '0;

    framebuffer_fill_engine_unit u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        draw_cmd_t c;
        draw_result_t r;
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("Verification failed");
            $finish;
        end
        if (in_valid && !in_stall)
        begin
            c.op = req_type;
            c.x = pos_x;
            c.y = pos_y;
            c.rw = rect_width;
            c.rh = rect_height;
            c.rad = radius;
            c.col = color;
            sb.note(c);
        end
        if (out_valid && !out_stall)
        begin
            r.rd = read_color;
            r.inr = in_range;
            r.cnt = pixels_written;
            sb.check(r);
        end
    end

    // The long hold-off lets the engine fill up and stall its request input.
    always @(negedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req = 0;
            hold_cnt = 400;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < rx_pct);
    end

    task automatic send_cmd(draw_cmd_t c);
        while ($urandom_range(0, 99) < tx_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        req_type <= c.op;
        pos_x <= c.x;
        pos_y <= c.y;
        rect_width <= c.rw;
        rect_height <= c.rh;
        radius <= c.rad;
        color <= c.col;
        do @(posedge clk); while (in_stall);
        sent++;
        if (c.op == REQ_PIXEL || c.op == REQ_CLEAR) last_color = c.col;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_size(logic idx, logic [8:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_size(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic draw_cmd_t mk(logic [2:0] op, int x, int y, int rw, int rh,
                                     int rad, logic [31:0] col);
        draw_cmd_t c;
        c.op = op;
        c.x = x[15:0];
        c.y = y[15:0];
        c.rw = rw[14:0];
        c.rh = rh[14:0];
        c.rad = rad[13:0];
        c.col = col;
        return c;
    endfunction

    function automatic draw_cmd_t rand_cmd();
        draw_cmd_t c;
        int pick, span;
        span = (sb.fw > sb.fh) ? sb.fw : sb.fh;
        pick = $urandom_range(0, 99);
        if (pick < 20) c.op = REQ_PIXEL;
        else if (pick < 40) c.op = REQ_READ;
        else if (pick < 60) c.op = REQ_RECT;
        else if (pick < 75) c.op = REQ_CIRCLE;
        else if (pick < 80) c.op = REQ_CLEAR;
        else if (pick < 90) c.op = REQ_KEY;
        else c.op = $urandom_range(0, 1) ? REQ_SPARE_6 : REQ_SPARE_7;
        if ($urandom_range(0, 4) != 0)
        begin
            c.x = 16'($urandom_range(0, sb.fw + 3) - 2);
            c.y = 16'($urandom_range(0, sb.fh + 3) - 2);
            c.rw = 15'($urandom_range(0, sb.fw + 2));
            c.rh = 15'($urandom_range(0, sb.fh + 2));
            c.rad = 14'($urandom_range(0, span));
        end
        else
        begin
            c.x = 16'($urandom());
            c.y = 16'($urandom());
            c.rw = 15'($urandom());
            c.rh = 15'($urandom());
            c.rad = 14'($urandom());
        end
        c.col = $urandom();
        // A key usually copies the low 24 bits of the last pixel or clear color; its top byte is random.
        if (c.op == REQ_KEY && $urandom_range(0, 3) != 0)
            c.col = {8'($urandom_range(0, 255)), last_color[23:0]};
        return c;
    endfunction

    initial
    begin
        logic [8:0] sizes [5][2];
        int total;
        sizes = '{'{9'd0, 9'd0}, '{9'd511, 9'd1}, '{9'd7, 9'd5}, '{9'd16, 9'd12},
                  '{9'd1, 9'd300}};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the full 256 x 256 frame.
        write_size(CFG_WIDTH, 9'd256);
        write_size(CFG_HEIGHT, 9'd256);
        send_cmd(mk(REQ_READ, 10, 10, 0, 0, 0, '0));
        send_cmd(mk(REQ_PIXEL, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        send_cmd(mk(REQ_PIXEL, 255, 255, 0, 0, 0, 32'h1234_5678));
        send_cmd(mk(REQ_PIXEL, 256, 0, 0, 0, 0, 32'hDEAD_BEEF));
        send_cmd(mk(REQ_PIXEL, -1, 5, 0, 0, 0, 32'hDEAD_BEEF));
        send_cmd(mk(REQ_PIXEL, -32768, 32767, 0, 0, 0, 32'hDEAD_BEEF));
        send_cmd(mk(REQ_READ, 0, 0, 0, 0, 0, '0));
        send_cmd(mk(REQ_READ, 255, 255, 0, 0, 0, '0));
        send_cmd(mk(REQ_READ, 32767, -32768, 0, 0, 0, '0));
        send_cmd(mk(REQ_RECT, 250, -3, 10, 6, 0, 32'hAB00_0001));
        send_cmd(mk(REQ_RECT, 5, 5, 0, 9, 0, 32'hAB00_0002));
        send_cmd(mk(REQ_RECT, 5, 5, 9, 0, 0, 32'hAB00_0002));
        send_cmd(mk(REQ_RECT, -32768, 100, 32767, 1, 0, 32'hAB00_0003));
        send_cmd(mk(REQ_RECT, 300, 300, 32767, 32767, 0, 32'hAB00_0004));
        send_cmd(mk(REQ_CIRCLE, 0, 0, 0, 0, 5, 32'h00C0_FFEE));
        send_cmd(mk(REQ_CIRCLE, 40, 40, 0, 0, 0, 32'h00C0_FFEE));
        send_cmd(mk(REQ_CIRCLE, -20, 300, 0, 0, 3, 32'h00C0_FFEE));
        send_cmd(mk(REQ_KEY, 0, 0, 0, 0, 0, 32'h5500_C0FF));
        send_cmd(mk(REQ_CIRCLE, 128, 128, 0, 0, 16383, 32'h7F12_3456));
        send_cmd(mk(REQ_KEY, 0, 0, 0, 0, 0, 32'h0012_3456));
        send_cmd(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 32'h8000_0001));
        send_cmd(mk(REQ_SPARE_6, 1, 1, 1, 1, 1, 32'h1));
        send_cmd(mk(REQ_SPARE_7, 1, 1, 1, 1, 1, 32'h1));
        send_cmd(mk(REQ_READ, 77, 33, 0, 0, 0, '0));
        drain();

        // Random part over several frame sizes and idling patterns.
        total = 0;
        for (int ph = 0; ph < 5; ph++)
        begin
            write_size(CFG_WIDTH, sizes[ph][0]);
            write_size(CFG_HEIGHT, sizes[ph][1]);
            for (int i = 0; i < 24; i++)
            begin
                if (total < 47)
                begin
                    tx_pct = 33;
                    rx_pct = 47;
                end
                else if (total < 94)
                begin
                    tx_pct = 47;
                    rx_pct = 33;
                end
                else
                begin
                    tx_pct = 0;
                    rx_pct = 0;
                end
                if (total == 60) hold_req = 1;
                if (total == 110)
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                    while (sb.pending.size() != 0) @(posedge clk);
                end
                send_cmd(rand_cmd());
                total++;
            end
            drain();
        end

        repeat (200) @(posedge clk);
        $display("Covered %0d commands of every type over 6 frame sizes, %0d results checked.",
                 sent, sb.checked);
        $display("Idling patterns on both sides, a long output hold-off and a full drain.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

FILE: sim.f
design/ffe_pkg.sv
design/ffe_ram.sv
design/framebuffer_fill_engine_unit.sv
dv/framebuffer_fill_engine_unit_test.sv
